// File: rtl/lpm_pkg.sv
// shared types, sizes and codes for the ipv4 longest prefix match block
// no dependencies; imported by every module of the block
package lpm_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 6;
	localparam int AS_W        = 32;
	localparam int IN_DATA_W   = 104;
	localparam int OUT_DATA_W  = 104;
	localparam logic [LEN_W-1:0] FULL_LENGTH = LEN_W'(32);

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef struct packed {
		logic [ADDR_W-1:0] prefix;
		logic [LEN_W-1:0]  length;
		logic [AS_W-1:0]   asn;
	} lpm_entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		lpm_entry_t       wr_entry;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
	} lpm_ram_req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] prefix;
		logic [LEN_W-1:0]  length;
		logic [AS_W-1:0]   asn;
		logic [ADDR_W-1:0] qaddr;
		logic              status;
	} lpm_result_t;

endpackage

// File: rtl/ipv4_longest_prefix_match.sv
// ipv4 longest prefix match: stream ports, field packing, table and sequencer
// depends on lpm_pkg, lpm_route_ram and lpm_scan
// sequence: append, clear and unused codes go from idle straight to the response state;
// a lookup scans each entry, then a last-compare state, then the response (empty table: straight to response)
// throughput: one item in flight; a lookup reads one table entry per cycle from the
// single read port
// reset: arst_n clears the entry count and the control state; no clearing pass of the table
module ipv4_longest_prefix_match
	import lpm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// address[31:0], route_prefix[63:32], route_length[69:64], route_as[101:70], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// matched_prefix[31:0], matched_length[37:32], matched_as[69:38],
	// queried_address[101:70], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// found[0], status[1]
	output logic [1:0]            m_tuser
);

	lpm_ram_req_t ram_req;
	lpm_entry_t   rd_entry;
	logic         rd_vld;
	lpm_result_t  res;

	lpm_route_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ram_req),
		.rd_entry (rd_entry),
		.rd_vld   (rd_vld)
	);

	lpm_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_func    (s_tuser),
		.in_address (s_tdata[31:0]),
		.in_prefix  (s_tdata[63:32]),
		.in_length  (s_tdata[69:64]),
		.in_as      (s_tdata[101:70]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res),
		.ram_req    (ram_req),
		.rd_entry   (rd_entry),
		.rd_vld     (rd_vld)
	);

	assign m_tdata = {2'b00, res.qaddr, res.asn, res.length, res.prefix};
	assign m_tuser = {res.status, res.found};

endmodule

// File: rtl/lpm_route_ram.sv
// route table storage: one write port, one read port, registered read data
// depends on lpm_pkg for the entry type and table depth
module lpm_route_ram
	import lpm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  lpm_ram_req_t req,
	output lpm_entry_t   rd_entry,
	output logic         rd_vld
);

	lpm_entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_entry;
		end
		if (req.rd_en) begin
			rd_entry <= mem[req.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld <= 1'b0;
		end else begin
			rd_vld <= req.rd_en;
		end
	end

endmodule

// File: rtl/lpm_scan.sv
// item sequencer: appends routes, clears the entry count, scans the table for a lookup, holds the result beat
// depends on lpm_pkg; drives lpm_route_ram through an lpm_ram_req_t
module lpm_scan
	import lpm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_func,
	input  logic [ADDR_W-1:0] in_address,
	input  logic [ADDR_W-1:0] in_prefix,
	input  logic [LEN_W-1:0]  in_length,
	input  logic [AS_W-1:0]   in_as,
	output logic              out_valid,
	input  logic              out_ready,
	output lpm_result_t       out_res,
	output lpm_ram_req_t      ram_req,
	input  lpm_entry_t        rd_entry,
	input  logic              rd_vld
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_LAST = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [ADDR_W-1:0] addr_q;
	lpm_entry_t        best_q;
	lpm_entry_t        best_nxt;
	lpm_result_t       res_q;
	lpm_result_t       out_q;
	logic              out_valid_q;
	logic              accept;
	logic              full;
	logic              hit;
	logic [ADDR_W-1:0] mask;
	logic [LEN_W-1:0]  len_clamped;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (cnt_q >= CNT_W'(TABLE_DEPTH));
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	assign len_clamped = (in_length > FULL_LENGTH) ? FULL_LENGTH : in_length;

	always_comb begin
		ram_req.wr_en           = accept && (in_func == FUNC_APPEND) && !full;
		ram_req.wr_idx          = cnt_q[IDX_W-1:0];
		ram_req.wr_entry.prefix = in_prefix;
		ram_req.wr_entry.length = len_clamped;
		ram_req.wr_entry.asn    = in_as;
		ram_req.rd_en           = (state_q == ST_SCAN);
		ram_req.rd_idx          = idx_q[IDX_W-1:0];
	end

	// a length of 32 shifts all ones out and leaves a full mask
	always_comb begin
		mask     = ~({ADDR_W{1'b1}} >> rd_entry.length);
		hit      = rd_vld && (rd_entry.length > best_q.length)
			&& (((addr_q ^ rd_entry.prefix) & mask) == '0);
		best_nxt = hit ? rd_entry : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			addr_q      <= '0;
			best_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && (in_func == FUNC_LOOKUP)) begin
				best_q <= '0;
			end else begin
				best_q <= best_nxt;
			end
			if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q       <= in_address;
						res_q.found  <= 1'b0;
						res_q.prefix <= '0;
						res_q.length <= '0;
						res_q.asn    <= '0;
						res_q.qaddr  <= (in_func == FUNC_LOOKUP) ? in_address : '0;
						res_q.status <= (in_func == FUNC_APPEND) && full;
						case (in_func)
							FUNC_APPEND: begin
								state_q <= ST_RESP;
								if (!full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							FUNC_LOOKUP: begin
								idx_q   <= '0;
								state_q <= (cnt_q != '0) ? ST_SCAN : ST_RESP;
							end
							FUNC_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (idx_q == cnt_q - CNT_W'(1)) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_LAST: begin
					// last read beat is compared this cycle
					res_q.found  <= (best_nxt.length != '0);
					res_q.prefix <= best_nxt.prefix;
					res_q.length <= best_nxt.length;
					res_q.asn    <= best_nxt.asn;
					state_q      <= ST_RESP;
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/lpm_checker.sv
// port-level checks for ipv4_longest_prefix_match, attached by bind
// depends on lpm_pkg for the data widths
module lpm_checker
	import lpm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser
);

	// a stalled result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a hit never comes with a dropped append
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("found and status both set");

	// a miss reports zero match fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[69:0] == '0)
		else $error("miss carries nonzero match fields");

	// a winning route has a length between 1 and 32
	a_hit_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[37:32] != '0 && m_tdata[37:32] <= 6'd32)
		else $error("hit with bad prefix length");

endmodule

bind ipv4_longest_prefix_match lpm_checker u_lpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
